// File: rtl/tws_pkg.sv
// ----------------------------------------------------------------------------
// tws_pkg
// Shared types and constants of the three-wire serial master.
// ----------------------------------------------------------------------------
`default_nettype none

package tws_pkg;

  localparam int unsigned BITS_PER_BYTE  = 8;
  localparam int unsigned BIT_IDX_W      = $clog2(BITS_PER_BYTE);
  localparam int unsigned DELAY_W        = 16;
  localparam int unsigned COUNT_W        = 5;

  localparam logic [COUNT_W-1:0]   MAX_READ_BYTES   = 5'd31;
  localparam logic [DELAY_W-1:0]   HALF_PERIOD_RST  = 16'd100;
  localparam logic [BIT_IDX_W-1:0] LAST_BIT         = BIT_IDX_W'(BITS_PER_BYTE - 1);

  // request codes; code 3 behaves as a plain tick
  localparam logic [1:0] REQ_TICK  = 2'd0;
  localparam logic [1:0] REQ_WRITE = 2'd1;
  localparam logic [1:0] REQ_READ  = 2'd2;

  typedef struct packed {
    logic [1:0]         req_type;
    logic [7:0]         command;
    logic [7:0]         write_data;
    logic [COUNT_W-1:0] read_count;
    logic               data_in;
  } req_t;

  typedef struct packed {
    logic       chip_enable;
    logic       serial_clock;
    logic       data_out;
    logic       data_drive;
    logic       busy_res;
    logic       read_valid;
    logic [7:0] read_data;
    logic       read_last;
  } res_t;

endpackage

`default_nettype wire

// File: rtl/tws_if.sv
// ----------------------------------------------------------------------------
// tws_if
// Valid/ready channels carrying request and result words.
// ----------------------------------------------------------------------------
`default_nettype none

interface tws_req_if;
  logic       valid;
  logic       ready;
  logic [1:0] req_type;
  logic [7:0] command;
  logic [7:0] write_data;
  logic [4:0] read_count;
  logic       data_in;

  modport source (output valid, req_type, command, write_data, read_count, data_in,
                  input ready);
  modport sink   (input valid, req_type, command, write_data, read_count, data_in,
                  output ready);
endinterface

interface tws_res_if;
  logic       valid;
  logic       ready;
  logic       chip_enable;
  logic       serial_clock;
  logic       data_out;
  logic       data_drive;
  logic       busy_res;
  logic       read_valid;
  logic [7:0] read_data;
  logic       read_last;

  modport source (output valid, chip_enable, serial_clock, data_out, data_drive,
                  busy_res, read_valid, read_data, read_last,
                  input ready);
  modport sink   (input valid, chip_enable, serial_clock, data_out, data_drive,
                  busy_res, read_valid, read_data, read_last,
                  output ready);
endinterface

`default_nettype wire

// File: rtl/tws_in_stage.sv
// ----------------------------------------------------------------------------
// tws_in_stage
// Input register: holds one request word until the sequencer steps on it.
// ----------------------------------------------------------------------------
`default_nettype none

module tws_in_stage (
  input  wire logic          clk,
  input  wire logic          rst,
  tws_req_if.sink            req,
  input  wire logic          step,
  output logic               word_valid,
  output tws_pkg::req_t      word
);

  assign req.ready = !word_valid || step;

  always_ff @(posedge clk) begin
    if (rst) begin
      word_valid <= 1'b0;
    end else if (req.ready) begin
      word_valid <= req.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (req.valid && req.ready) begin
      word.req_type   <= req.req_type;
      word.command    <= req.command;
      word.write_data <= req.write_data;
      word.read_count <= req.read_count;
      word.data_in    <= req.data_in;
    end
  end

endmodule

`default_nettype wire

// File: rtl/tws_seq.sv
// ----------------------------------------------------------------------------
// tws_seq
// Pin sequencer: one tick per step, produces the pin levels after the tick.
// ----------------------------------------------------------------------------
`default_nettype none

module tws_seq (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         cfg_we,
  input  wire logic [tws_pkg::DELAY_W-1:0]  cfg_wdata,
  input  wire logic                         step,
  input  wire tws_pkg::req_t                word,
  output tws_pkg::res_t                     res_next
);

  typedef enum logic [2:0] {
    PH_IDLE, PH_START, PH_GAP, PH_WLOW, PH_WHIGH, PH_RLOW, PH_RHIGH
  } phase_t;

  phase_t                            phase, phase_next;
  logic [tws_pkg::DELAY_W-1:0]       half_period;
  logic [tws_pkg::DELAY_W-1:0]       delay_count, delay_count_next, delay_dec, delay_load;
  logic [tws_pkg::BIT_IDX_W-1:0]     bit_index, bit_index_next;
  logic [tws_pkg::COUNT_W-1:0]       bytes_left, bytes_left_next, bytes_dec;
  logic [7:0]                        shift_byte, shift_byte_next;
  logic [7:0]                        pending_data, pending_data_next;
  logic                              is_read, is_read_next;
  logic                              enable_level, enable_level_next;
  logic                              clock_level, clock_level_next;
  logic                              drive_level, drive_level_next;
  logic                              drive_enable, drive_enable_next;
  logic                              rvalid, rlast;
  logic [7:0]                        rdata;

  // zero delay acts as one tick
  assign delay_load = (half_period == '0) ? tws_pkg::DELAY_W'(1) : half_period;
  assign delay_dec  = tws_pkg::DELAY_W'(delay_count - tws_pkg::DELAY_W'(1));
  assign bytes_dec  = tws_pkg::COUNT_W'(bytes_left - tws_pkg::COUNT_W'(1));

  always_comb begin
    phase_next        = phase;
    delay_count_next  = delay_count;
    bit_index_next    = bit_index;
    bytes_left_next   = bytes_left;
    shift_byte_next   = shift_byte;
    pending_data_next = pending_data;
    is_read_next      = is_read;
    enable_level_next = enable_level;
    clock_level_next  = clock_level;
    drive_level_next  = drive_level;
    drive_enable_next = drive_enable;
    rvalid            = 1'b0;
    rlast             = 1'b0;
    rdata             = '0;

    if (phase == PH_IDLE) begin
      if (word.req_type inside {tws_pkg::REQ_WRITE, tws_pkg::REQ_READ}) begin
        is_read_next      = (word.req_type == tws_pkg::REQ_READ);
        shift_byte_next   = word.command;
        pending_data_next = word.write_data;
        if (word.req_type == tws_pkg::REQ_READ) begin
          bytes_left_next = (word.read_count > tws_pkg::MAX_READ_BYTES) ?
                            tws_pkg::MAX_READ_BYTES : word.read_count;
        end else begin
          bytes_left_next = tws_pkg::COUNT_W'(1);
        end
        bit_index_next    = '0;
        clock_level_next  = 1'b0;
        enable_level_next = 1'b0;
        phase_next        = PH_START;
        delay_count_next  = delay_load;
      end
    end else begin
      delay_count_next = delay_dec;
      if (delay_dec == '0) begin
        delay_count_next = delay_load;
        case (phase)
          PH_START: begin
            enable_level_next = 1'b1;
            drive_enable_next = 1'b1;
            bit_index_next    = '0;
            phase_next        = PH_GAP;
          end
          PH_GAP: begin
            drive_level_next = shift_byte[0];
            clock_level_next = 1'b0;
            phase_next       = PH_WLOW;
          end
          PH_WLOW: begin
            clock_level_next = 1'b1;
            shift_byte_next  = {1'b0, shift_byte[7:1]};
            phase_next       = PH_WHIGH;
          end
          PH_WHIGH: begin
            if (bit_index != tws_pkg::LAST_BIT) begin
              bit_index_next   = tws_pkg::BIT_IDX_W'(bit_index + tws_pkg::BIT_IDX_W'(1));
              drive_level_next = shift_byte[0];
              clock_level_next = 1'b0;
              phase_next       = PH_WLOW;
            end else if (is_read) begin
              if (bytes_left != '0) begin
                drive_enable_next = 1'b0;
                drive_level_next  = 1'b0;
                clock_level_next  = 1'b0;
                bit_index_next    = '0;
                shift_byte_next   = '0;
                phase_next        = PH_RLOW;
              end else begin
                enable_level_next = 1'b0;
                phase_next        = PH_IDLE;
              end
            end else if (bytes_left != '0) begin
              // command done, data byte follows after a gap
              bytes_left_next = '0;
              shift_byte_next = pending_data;
              bit_index_next  = '0;
              phase_next      = PH_GAP;
            end else begin
              enable_level_next = 1'b0;
              phase_next        = PH_IDLE;
            end
          end
          PH_RLOW: begin
            shift_byte_next[bit_index] = shift_byte[bit_index] | word.data_in;
            clock_level_next = 1'b1;
            phase_next       = PH_RHIGH;
          end
          PH_RHIGH: begin
            if (bit_index != tws_pkg::LAST_BIT) begin
              bit_index_next   = tws_pkg::BIT_IDX_W'(bit_index + tws_pkg::BIT_IDX_W'(1));
              clock_level_next = 1'b0;
              phase_next       = PH_RLOW;
            end else begin
              rvalid          = 1'b1;
              rdata           = shift_byte;
              bytes_left_next = bytes_dec;
              rlast           = (bytes_dec == '0);
              if (bytes_dec == '0) begin
                enable_level_next = 1'b0;
                phase_next        = PH_IDLE;
              end else begin
                drive_enable_next = 1'b0;
                drive_level_next  = 1'b0;
                clock_level_next  = 1'b0;
                bit_index_next    = '0;
                shift_byte_next   = '0;
                phase_next        = PH_RLOW;
              end
            end
          end
          default: begin
            enable_level_next = 1'b0;
            phase_next        = PH_IDLE;
          end
        endcase
      end
    end

    res_next.chip_enable  = enable_level_next;
    res_next.serial_clock = clock_level_next;
    res_next.data_out     = drive_level_next;
    res_next.data_drive   = drive_enable_next;
    res_next.busy_res     = (phase_next != PH_IDLE);
    res_next.read_valid   = rvalid;
    res_next.read_data    = rdata;
    res_next.read_last    = rlast;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      half_period <= tws_pkg::HALF_PERIOD_RST;
    end else if (cfg_we) begin
      half_period <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_IDLE;
      delay_count  <= '0;
      bit_index    <= '0;
      bytes_left   <= '0;
      shift_byte   <= '0;
      pending_data <= '0;
      is_read      <= 1'b0;
      enable_level <= 1'b0;
      clock_level  <= 1'b0;
      drive_level  <= 1'b0;
      drive_enable <= 1'b1;
    end else if (step) begin
      phase        <= phase_next;
      delay_count  <= delay_count_next;
      bit_index    <= bit_index_next;
      bytes_left   <= bytes_left_next;
      shift_byte   <= shift_byte_next;
      pending_data <= pending_data_next;
      is_read      <= is_read_next;
      enable_level <= enable_level_next;
      clock_level  <= clock_level_next;
      drive_level  <= drive_level_next;
      drive_enable <= drive_enable_next;
    end
  end

endmodule

`default_nettype wire

// File: rtl/tws_out_stage.sv
// ----------------------------------------------------------------------------
// tws_out_stage
// Result register: holds one result word until the sink takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module tws_out_stage (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           step,
  input  wire tws_pkg::res_t  res_next,
  output logic                can_take,
  tws_res_if.source           res
);

  tws_pkg::res_t word;

  assign can_take = !res.valid || res.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      res.valid <= 1'b0;
    end else if (can_take) begin
      res.valid <= step;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      word <= res_next;
    end
  end

  assign res.chip_enable  = word.chip_enable;
  assign res.serial_clock = word.serial_clock;
  assign res.data_out     = word.data_out;
  assign res.data_drive   = word.data_drive;
  assign res.busy_res     = word.busy_res;
  assign res.read_valid   = word.read_valid;
  assign res.read_data    = word.read_data;
  assign res.read_last    = word.read_last;

endmodule

`default_nettype wire

// File: rtl/three_wire_serial_master.sv
// ----------------------------------------------------------------------------
// three_wire_serial_master
// Tick-driven master for a chip-enable / clock / data three-wire link.
// ----------------------------------------------------------------------------
//   channel | dir | handshake        | word
//   req     | in  | valid / ready    | req_type, command, write_data,
//           |     |                  | read_count, data_in
//   res     | out | valid / ready    | pin levels, busy_res, read byte
//   cfg     | in  | cfg_we           | half_period_ticks (cfg_wdata)
//
// One request word in, one result word out, one word per cycle sustained while the sink takes every result.
// Path: input register, then sequencer into result register.
// The sequencer only steps when the result register is free or being taken.
// Synchronous reset: half period 100, link idle, data line driven low.
// ----------------------------------------------------------------------------
`default_nettype none

module three_wire_serial_master (
  input  wire logic                        clk,
  input  wire logic                        rst,
  tws_req_if.sink                          req,
  tws_res_if.source                        res,
  input  wire logic                        cfg_we,
  input  wire logic [tws_pkg::DELAY_W-1:0] cfg_wdata
);

  logic          word_valid;
  logic          can_take;
  logic          step;
  tws_pkg::req_t word;
  tws_pkg::res_t res_next;

  assign step = word_valid && can_take;

  tws_in_stage u_in (
    .clk        (clk),
    .rst        (rst),
    .req        (req),
    .step       (step),
    .word_valid (word_valid),
    .word       (word)
  );

  tws_seq u_seq (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .step      (step),
    .word      (word),
    .res_next  (res_next)
  );

  tws_out_stage u_out (
    .clk      (clk),
    .rst      (rst),
    .step     (step),
    .res_next (res_next),
    .can_take (can_take),
    .res      (res)
  );

endmodule

`default_nettype wire

// File: rtl/tws_checker.sv
// ----------------------------------------------------------------------------
// tws_checker
// Port-level checks of the three-wire serial master.
// ----------------------------------------------------------------------------
`default_nettype none

module tws_checker (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       res_valid,
  input wire logic       res_ready,
  input wire logic       chip_enable,
  input wire logic       data_drive,
  input wire logic       busy_res,
  input wire logic       read_valid,
  input wire logic [7:0] read_data,
  input wire logic       read_last
);

  // stalled result word holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(read_data) && $stable(busy_res))
    else $error("result word changed under stall");

  a_rst_empty: assert property (@(posedge clk) rst |=> !res_valid)
    else $error("result valid straight after reset");

  // last byte of a read ends the transaction
  a_last_idle: assert property (@(posedge clk) disable iff (rst)
    res_valid && read_last |-> read_valid && !busy_res)
    else $error("read_last without end of transaction");

  // idle link has enable low
  a_idle_ce: assert property (@(posedge clk) disable iff (rst)
    res_valid && !busy_res |-> !chip_enable)
    else $error("chip enable high while idle");

  // a byte read means the data line was released
  a_read_released: assert property (@(posedge clk) disable iff (rst)
    res_valid && read_valid |-> !data_drive)
    else $error("data line driven during read");

endmodule

bind three_wire_serial_master tws_checker u_tws_checker (
  .clk         (clk),
  .rst         (rst),
  .res_valid   (res.valid),
  .res_ready   (res.ready),
  .chip_enable (res.chip_enable),
  .data_drive  (res.data_drive),
  .busy_res    (res.busy_res),
  .read_valid  (res.read_valid),
  .read_data   (res.read_data),
  .read_last   (res.read_last)
);

`default_nettype wire
